[design/qrv_pkg.sv]
// Shared constants, widths and the arctangent table for the quaternion to
// rotation vector unit. No dependencies; imported by every module of the block.
package qrv_pkg;

   localparam int CORDIC_STEPS = 16;
   localparam int ISQ_STEPS    = 16;
   localparam int QUO_W        = 15;
   localparam int LANE_LAT     = QUO_W + 2;
   localparam int VEC_W        = 28;
   localparam int ANG_W        = 24;
   localparam int ANGU_W       = 22;
   localparam int NORM_W       = 16;
   localparam int MAG_W        = 17;
   localparam int NUM_W        = 40;
   localparam int DEN_W        = NORM_W + 7;

   localparam logic signed [ANG_W-1:0] HALF_PI_Q20 = 24'sd1647099;

   function automatic logic signed [ANG_W-1:0] atan_q20(input int idx);
      logic signed [ANG_W-1:0] val;
      unique case (idx)
         0:  val = 24'sd823550;
         1:  val = 24'sd486170;
         2:  val = 24'sd256879;
         3:  val = 24'sd130396;
         4:  val = 24'sd65451;
         5:  val = 24'sd32757;
         6:  val = 24'sd16383;
         7:  val = 24'sd8192;
         8:  val = 24'sd4096;
         9:  val = 24'sd2048;
         10: val = 24'sd1024;
         11: val = 24'sd512;
         12: val = 24'sd256;
         13: val = 24'sd128;
         14: val = 24'sd64;
         15: val = 24'sd32;
         16: val = 24'sd16;
         17: val = 24'sd8;
         18: val = 24'sd4;
         19: val = 24'sd2;
         20: val = 24'sd1;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

[design/qrv_scale_lane.sv]
// One component lane: scales the angle by a component magnitude and divides
// by the norm with a restoring divider, one quotient bit per stage. Uses qrv_pkg.
module qrv_scale_lane import qrv_pkg::*; (
   input  logic              clock,
   input  logic              en,
   input  logic [ANGU_W-1:0] ang,
   input  logic [MAG_W-1:0]  mag,
   input  logic [NORM_W-1:0] norm,
   output logic [QUO_W-1:0]  quo,
   output logic              sat
);

   logic [NUM_W-1:0]  num_ff;
   logic [NORM_W-1:0] norm_ff;

   logic [NUM_W-1:0]  rem_ff [0:QUO_W];
   logic [DEN_W-1:0]  den_ff [0:QUO_W];
   logic [QUO_W-1:0]  quo_ff [0:QUO_W];
   logic              sat_ff [0:QUO_W];

   logic [NUM_W-1:0]  rem_in [1:QUO_W];
   logic [QUO_W-1:0]  quo_in [1:QUO_W];
   logic [NUM_W-1:0]  n_sum;
   logic [DEN_W-1:0]  den_new;

   assign n_sum   = num_ff + NUM_W'({norm_ff, 6'b0});
   assign den_new = {norm_ff, 7'b0};

   always_comb begin
      logic [NUM_W-1:0] dsh;
      for (int j = 0; j < QUO_W; j++) begin
         dsh = NUM_W'(den_ff[j]) << (QUO_W - 1 - j);
         if (rem_ff[j] >= dsh) begin
            rem_in[j+1] = rem_ff[j] - dsh;
            quo_in[j+1] = {quo_ff[j][QUO_W-2:0], 1'b1};
         end else begin
            rem_in[j+1] = rem_ff[j];
            quo_in[j+1] = {quo_ff[j][QUO_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         num_ff    <= NUM_W'(ang) * NUM_W'(mag);
         norm_ff   <= norm;
         rem_ff[0] <= n_sum;
         den_ff[0] <= den_new;
         quo_ff[0] <= '0;
         sat_ff[0] <= n_sum >= (NUM_W'(den_new) << QUO_W);
         for (int j = 0; j < QUO_W; j++) begin
            rem_ff[j+1] <= rem_in[j+1];
            den_ff[j+1] <= den_ff[j];
            quo_ff[j+1] <= quo_in[j+1];
            sat_ff[j+1] <= sat_ff[j];
         end
      end
   end

   assign quo = quo_ff[QUO_W];
   assign sat = sat_ff[QUO_W];

endmodule

[design/quaternion_to_rotation_vector_unit.sv]
// Top level of the quaternion to rotation vector unit: norm, CORDIC angle and
// per-component scaling pipeline. Depends on qrv_pkg and qrv_scale_lane.
//
// Each req word carries one quaternion (w, x, y, z) in signed Q1.15. Each rsp
// word carries the rotation vector (x, y, z) in signed Q3.12 radians, with
// tuser set when the vector-part norm was below the limit and the vector was
// forced to zero. The csr channel writes the 15 bit norm limit (reset value 1)
// and is always ready; it should be written only while the unit is empty.
// The unit is a fixed 54-stage pipeline: two stages of squares and sum, 16
// square root stages, one set-up stage, 16 CORDIC stages, one clamp stage,
// 17 stages of multiply and restoring division, and the output register.
// A word can enter every cycle unless the receiver stalls the pipeline.
// Reset clears all valid bits and sets the limit to 1. When the receiver
// stalls the whole pipeline holds; req_tready then follows the output
// register being free or being taken, so nothing is lost or repeated.
module quaternion_to_rotation_vector_unit import qrv_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,  // quat_w, quat_x, quat_y, quat_z
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,  // rot_x, rot_y, rot_z
   output logic        rsp_tuser,  // near_zero
   input  logic        csr_tvalid,
   output logic        csr_tready,
   input  logic [15:0] csr_tdata   // zero_norm_limit
);

   logic        en;
   logic [14:0] limit_ff;

   logic                     s1_vld_ff;
   logic signed [15:0]       s1_quat_ff [0:3];
   logic [31:0]              s1_sq_ff [0:2];
   logic signed [31:0]       sq_prod [0:2];

   logic [ISQ_STEPS:0]       sq_vld_ff;
   logic [31:0]              sq_rem_ff [0:ISQ_STEPS];
   logic [31:0]              sq_root_ff [0:ISQ_STEPS];
   logic signed [15:0]       sq_quat_ff [0:ISQ_STEPS][0:3];
   logic [31:0]              sq_rem_in [1:ISQ_STEPS];
   logic [31:0]              sq_root_in [1:ISQ_STEPS];

   logic [CORDIC_STEPS:0]    cd_vld_ff;
   logic signed [VEC_W-1:0]  cd_vx_ff [0:CORDIC_STEPS];
   logic signed [VEC_W-1:0]  cd_vy_ff [0:CORDIC_STEPS];
   logic signed [ANG_W-1:0]  cd_ang_ff [0:CORDIC_STEPS];
   logic signed [15:0]       cd_quat_ff [0:CORDIC_STEPS][0:2];
   logic [NORM_W-1:0]        cd_norm_ff [0:CORDIC_STEPS];
   logic                     cd_near_ff [0:CORDIC_STEPS];
   logic                     cd_zero_ff [0:CORDIC_STEPS];
   logic signed [VEC_W-1:0]  cd_vx_in [1:CORDIC_STEPS];
   logic signed [VEC_W-1:0]  cd_vy_in [1:CORDIC_STEPS];
   logic signed [ANG_W-1:0]  cd_ang_in [1:CORDIC_STEPS];

   logic [NORM_W-1:0]        norm;
   logic signed [VEC_W-1:0]  w_ext;
   logic signed [VEC_W-1:0]  n_ext;

   logic                     cl_vld_ff;
   logic [ANGU_W-1:0]        cl_ang_ff;
   logic signed [15:0]       cl_quat_ff [0:2];
   logic [NORM_W-1:0]        cl_norm_ff;
   logic                     cl_near_ff;
   logic                     cl_zero_ff;
   logic [MAG_W-1:0]         cl_mag [0:2];

   logic [QUO_W-1:0]         ln_quo [0:2];
   logic                     ln_sat [0:2];

   logic [LANE_LAT:1]        dl_vld_ff;
   logic [2:0]               dl_neg_ff [1:LANE_LAT];
   logic                     dl_near_ff [1:LANE_LAT];
   logic                     dl_zero_ff [1:LANE_LAT];

   logic                     out_vld_ff;
   logic                     out_near_ff;
   logic signed [15:0]       out_rot_ff [0:2];

   assign en         = !out_vld_ff || rsp_tready;
   assign req_tready = en;
   assign csr_tready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= 15'd1;
      end else if (csr_tvalid) begin
         limit_ff <= csr_tdata[14:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         sq_vld_ff  <= '0;
         cd_vld_ff  <= '0;
         cl_vld_ff  <= 1'b0;
         dl_vld_ff  <= '0;
         out_vld_ff <= 1'b0;
      end else if (en) begin
         s1_vld_ff  <= req_tvalid;
         sq_vld_ff  <= {sq_vld_ff[ISQ_STEPS-1:0], s1_vld_ff};
         cd_vld_ff  <= {cd_vld_ff[CORDIC_STEPS-1:0], sq_vld_ff[ISQ_STEPS]};
         cl_vld_ff  <= cd_vld_ff[CORDIC_STEPS];
         dl_vld_ff  <= {dl_vld_ff[LANE_LAT-1:1], cl_vld_ff};
         out_vld_ff <= dl_vld_ff[LANE_LAT];
      end
   end

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         sq_prod[c] = 32'($signed(req_tdata[16*c+16 +: 16]))
                      * 32'($signed(req_tdata[16*c+16 +: 16]));
      end
   end

   always_comb begin
      logic [31:0] bitv;
      logic [31:0] trial;
      for (int k = 0; k < ISQ_STEPS; k++) begin
         bitv  = 32'd1 << (30 - 2 * k);
         trial = sq_root_ff[k] + bitv;
         if (sq_rem_ff[k] >= trial) begin
            sq_rem_in[k+1]  = sq_rem_ff[k] - trial;
            sq_root_in[k+1] = (sq_root_ff[k] >> 1) + bitv;
         end else begin
            sq_rem_in[k+1]  = sq_rem_ff[k];
            sq_root_in[k+1] = sq_root_ff[k] >> 1;
         end
      end
   end

   assign norm  = sq_root_ff[ISQ_STEPS][NORM_W-1:0];
   assign w_ext = VEC_W'(sq_quat_ff[ISQ_STEPS][0]);
   assign n_ext = VEC_W'({1'b0, norm});

   always_comb begin
      logic signed [VEC_W-1:0] dx;
      logic signed [VEC_W-1:0] dy;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         dx = cd_vy_ff[i] >>> i;
         dy = cd_vx_ff[i] >>> i;
         if (!cd_vy_ff[i][VEC_W-1]) begin
            cd_vx_in[i+1]  = cd_vx_ff[i] + dx;
            cd_vy_in[i+1]  = cd_vy_ff[i] - dy;
            cd_ang_in[i+1] = cd_ang_ff[i] + atan_q20(i);
         end else begin
            cd_vx_in[i+1]  = cd_vx_ff[i] - dx;
            cd_vy_in[i+1]  = cd_vy_ff[i] + dy;
            cd_ang_in[i+1] = cd_ang_ff[i] - atan_q20(i);
         end
      end
   end

   always_comb begin
      logic signed [MAG_W-1:0] ce;
      for (int c = 0; c < 3; c++) begin
         ce = MAG_W'(cl_quat_ff[c]);
         cl_mag[c] = ce[MAG_W-1] ? MAG_W'(-ce) : MAG_W'(ce);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_quat_ff[0] <= req_tdata[15:0];
         s1_quat_ff[1] <= req_tdata[31:16];
         s1_quat_ff[2] <= req_tdata[47:32];
         s1_quat_ff[3] <= req_tdata[63:48];
         for (int c = 0; c < 3; c++) begin
            s1_sq_ff[c] <= sq_prod[c];
         end

         sq_rem_ff[0]  <= s1_sq_ff[0] + s1_sq_ff[1] + s1_sq_ff[2];
         sq_root_ff[0] <= '0;
         sq_quat_ff[0] <= s1_quat_ff;
         for (int k = 0; k < ISQ_STEPS; k++) begin
            sq_rem_ff[k+1]  <= sq_rem_in[k+1];
            sq_root_ff[k+1] <= sq_root_in[k+1];
            sq_quat_ff[k+1] <= sq_quat_ff[k];
         end

         if (!w_ext[VEC_W-1]) begin
            cd_vx_ff[0]  <= w_ext <<< 8;
            cd_vy_ff[0]  <= n_ext <<< 8;
            cd_ang_ff[0] <= '0;
         end else begin
            cd_vx_ff[0]  <= n_ext <<< 8;
            cd_vy_ff[0]  <= (-w_ext) <<< 8;
            cd_ang_ff[0] <= HALF_PI_Q20;
         end
         for (int c = 0; c < 3; c++) begin
            cd_quat_ff[0][c] <= sq_quat_ff[ISQ_STEPS][c+1];
         end
         cd_norm_ff[0] <= norm;
         cd_near_ff[0] <= norm < NORM_W'(limit_ff);
         cd_zero_ff[0] <= norm == '0;
         for (int i = 0; i < CORDIC_STEPS; i++) begin
            cd_vx_ff[i+1]   <= cd_vx_in[i+1];
            cd_vy_ff[i+1]   <= cd_vy_in[i+1];
            cd_ang_ff[i+1]  <= cd_ang_in[i+1];
            cd_quat_ff[i+1] <= cd_quat_ff[i];
            cd_norm_ff[i+1] <= cd_norm_ff[i];
            cd_near_ff[i+1] <= cd_near_ff[i];
            cd_zero_ff[i+1] <= cd_zero_ff[i];
         end

         cl_ang_ff  <= cd_ang_ff[CORDIC_STEPS][ANG_W-1] ? '0
                       : cd_ang_ff[CORDIC_STEPS][ANGU_W-1:0];
         cl_quat_ff <= cd_quat_ff[CORDIC_STEPS];
         cl_norm_ff <= cd_norm_ff[CORDIC_STEPS];
         cl_near_ff <= cd_near_ff[CORDIC_STEPS];
         cl_zero_ff <= cd_zero_ff[CORDIC_STEPS];

         dl_neg_ff[1]  <= {cl_quat_ff[2][15], cl_quat_ff[1][15], cl_quat_ff[0][15]};
         dl_near_ff[1] <= cl_near_ff;
         dl_zero_ff[1] <= cl_zero_ff;
         for (int d = 1; d < LANE_LAT; d++) begin
            dl_neg_ff[d+1]  <= dl_neg_ff[d];
            dl_near_ff[d+1] <= dl_near_ff[d];
            dl_zero_ff[d+1] <= dl_zero_ff[d];
         end

         out_near_ff <= dl_near_ff[LANE_LAT];
         for (int c = 0; c < 3; c++) begin
            if (dl_near_ff[LANE_LAT] || dl_zero_ff[LANE_LAT]) begin
               out_rot_ff[c] <= '0;
            end else if (ln_sat[c]) begin
               out_rot_ff[c] <= dl_neg_ff[LANE_LAT][c] ? -16'sd32767 : 16'sd32767;
            end else if (dl_neg_ff[LANE_LAT][c]) begin
               out_rot_ff[c] <= -$signed({1'b0, ln_quo[c]});
            end else begin
               out_rot_ff[c] <= $signed({1'b0, ln_quo[c]});
            end
         end
      end
   end

   for (genvar g = 0; g < 3; g++) begin : g_lane
      qrv_scale_lane u_lane (
         .clock (clock),
         .en    (en),
         .ang   (cl_ang_ff),
         .mag   (cl_mag[g]),
         .norm  (cl_norm_ff),
         .quo   (ln_quo[g]),
         .sat   (ln_sat[g])
      );
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {out_rot_ff[2], out_rot_ff[1], out_rot_ff[0]};
   assign rsp_tuser  = out_near_ff;

   a_near_zero_data: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == '0)
      else $error("Flagged word carries a nonzero vector.");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("Output valid after reset.");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(cd_vld_ff) && $stable(sq_vld_ff))
      else $error("Pipeline moved during a stall.");

endmodule
